// ===== hw/rtl/ats_pkg.sv =====
// Shared codes and constants for the animation timeline stepper.
package ats_pkg;

  localparam int DUR_W = 16;
  localparam int LOOP_W = 17;
  localparam int FUNC_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [FUNC_W-1:0] {
    FN_START  = 3'd0,
    FN_TICK   = 3'd1,
    FN_PAUSE  = 3'd2,
    FN_RESUME = 3'd3,
    FN_FINISH = 3'd4,
    FN_CANCEL = 3'd5
  } func_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_DURATION = 2'd1,
    CFG_LOOPS    = 2'd2,
    CFG_YOYO     = 2'd3
  } cfg_index_t;

endpackage

// ===== hw/rtl/ats_alu.sv =====
// Shared add/subtract unit with carry out (carry set on subtract means no borrow).
module ats_alu #(
  parameter int AW = 32
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  output logic [AW-1:0] sum,
  output logic          carry
);

  logic [AW-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{AW{1'b0}}, sub};

endmodule

// ===== hw/rtl/animation_timeline_stepper.sv =====
// Animation timeline stepper: timestamped commands in, progress beats out.
//
// Input channel (in_valid/in_stall) carries func, now_time and stop_request.
// Output channel (out_valid/out_stall) carries one result beat per input beat:
// progress (Q1.FRAC_BITS), progress_valid, finished, running, is_paused.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes delay_time,
// leg_duration, loop_total and yoyo_mode; cfg_ready is always high.
//
// One input beat is handled at a time. A tick on a running, unpaused run walks
// the shared add/subtract unit through elapsed time, delay and duration checks,
// then a restoring division one quotient bit per cycle, and a mirror step on
// reverse legs, before the output register is loaded. A pause on a running,
// unpaused run only sums elapsed time; other commands go straight to output.
// in_stall is high from accept until the result is written to the output
// register; a new beat can be accepted while that result waits.
// If out_stall holds the output register full, the finished item waits in
// its last step and in_stall stays high.
// Synchronous reset clears the run state and output valid and loads the
// registers with delay 0, duration 1, one loop, no yoyo.
module animation_timeline_stepper import ats_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [31:0]           now_time,
  input  logic                  stop_request,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FRAC_BITS:0]    progress,
  output logic                  progress_valid,
  output logic                  finished,
  output logic                  running,
  output logic                  is_paused
);

  localparam int PW  = FRAC_BITS + 1;
  localparam int AW0 = (TIME_WIDTH > PW) ? TIME_WIDTH : PW;
  localparam int AW  = (AW0 > DUR_W + 1) ? AW0 : DUR_W + 1;
  localparam int CW  = $clog2(FRAC_BITS);
  localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUB  = 8'b0000_0010,
    S_ADD  = 8'b0000_0100,
    S_DLY  = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_MIR  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [DUR_W-1:0]  delay_time;
  logic [DUR_W-1:0]  leg_duration;
  logic [LOOP_W-1:0] loop_total;
  logic              yoyo_mode;

  // run state
  logic [TIME_WIDTH-1:0] leg_start, leg_start_next;
  logic [TIME_WIDTH-1:0] banked, banked_next;
  logic [DUR_W-1:0]      cycles_left, cycles_left_next;
  logic                  rev, rev_next;
  logic                  hold, hold_next;
  logic                  active, active_next;

  // item being worked
  logic [FUNC_W-1:0]     func_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic                  stop_r;
  logic                  prog_ok;
  logic                  leg_done;
  logic [AW-1:0]         acc;
  logic [PW-1:0]         q;
  logic [CW-1:0]         cnt;

  logic [TIME_WIDTH+31:0] now_wide;
  logic [DUR_W-1:0]       dur;
  logic [AW-1:0]          alu_a, alu_b, alu_sum;
  logic                   alu_sub, alu_carry;
  logic                   out_free;
  logic                   out_load;
  logic                   do_count;
  logic [PW-1:0]          o_prog;
  logic                   o_pv, o_fin;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_OUT) && out_free;
  assign now_wide  = {{TIME_WIDTH{1'b0}}, now_time};
  assign dur       = (leg_duration == '0) ? DUR_W'(1) : leg_duration;

  ats_alu #(.AW(AW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .carry(alu_carry)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_SUB: begin
        alu_a   = AW'(now_r);
        alu_b   = AW'(leg_start);
        alu_sub = 1'b1;
      end
      S_ADD: begin
        alu_a = acc;
        alu_b = AW'(banked);
      end
      S_DLY: begin
        alu_a   = acc;
        alu_b   = AW'(delay_time);
        alu_sub = 1'b1;
      end
      S_CMP: begin
        alu_a   = acc;
        alu_b   = AW'(dur);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {acc[AW-2:0], 1'b0};
        alu_b   = AW'(dur);
        alu_sub = 1'b1;
      end
      S_MIR: begin
        alu_a   = AW'(ONE);
        alu_b   = AW'(q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
      end
    endcase
  end

  // bookkeeping applied when the result is written
  always_comb begin
    leg_start_next   = leg_start;
    banked_next      = banked;
    cycles_left_next = cycles_left;
    rev_next         = rev;
    hold_next        = hold;
    active_next      = active;
    o_prog           = '0;
    o_pv             = 1'b0;
    o_fin            = 1'b0;
    do_count         = 1'b0;
    case (func_r)
      FN_START: begin
        active_next      = 1'b1;
        hold_next        = 1'b0;
        rev_next         = 1'b0;
        leg_start_next   = now_r;
        banked_next      = '0;
        cycles_left_next = loop_total[LOOP_W-1] ? '0 : loop_total[DUR_W-1:0];
      end
      FN_TICK: begin
        if (prog_ok) begin
          o_prog = q;
          o_pv   = 1'b1;
          if (stop_r) begin
            o_fin = 1'b1;
          end else if (leg_done) begin
            if (yoyo_mode) begin
              rev_next = !rev;
              if (rev) begin
                do_count = 1'b1;
              end else begin
                leg_start_next = now_r;
                banked_next    = '0;
              end
            end else begin
              do_count = 1'b1;
            end
          end
        end
      end
      FN_PAUSE: begin
        if (active && !hold) begin
          banked_next = acc[TIME_WIDTH-1:0];
          hold_next   = 1'b1;
        end
      end
      FN_RESUME: begin
        if (active && hold) begin
          leg_start_next = now_r;
          hold_next      = 1'b0;
        end
      end
      FN_FINISH: begin
        if (active) begin
          o_prog = rev ? '0 : ONE;
          o_pv   = 1'b1;
          o_fin  = 1'b1;
        end
      end
      FN_CANCEL: begin
        if (active) begin
          active_next = 1'b0;
          hold_next   = 1'b0;
          rev_next    = 1'b0;
        end
      end
      default: begin
        o_pv = 1'b0;
      end
    endcase
    if (do_count) begin
      if (!loop_total[LOOP_W-1] && cycles_left < DUR_W'(2)) begin
        cycles_left_next = '0;
        o_fin            = 1'b1;
      end else begin
        if (!loop_total[LOOP_W-1]) begin
          cycles_left_next = cycles_left - DUR_W'(1);
        end
        leg_start_next = now_r;
        banked_next    = '0;
      end
    end
    if (o_fin) begin
      active_next = 1'b0;
      hold_next   = 1'b0;
      rev_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_time   <= '0;
      leg_duration <= DUR_W'(1);
      loop_total   <= LOOP_W'(1);
      yoyo_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELAY:    delay_time   <= cfg_data[DUR_W-1:0];
        CFG_DURATION: leg_duration <= cfg_data[DUR_W-1:0];
        CFG_LOOPS:    loop_total   <= cfg_data[LOOP_W-1:0];
        CFG_YOYO:     yoyo_mode    <= cfg_data[0];
        default:      yoyo_mode    <= yoyo_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      leg_start   <= '0;
      banked      <= '0;
      cycles_left <= '0;
      rev         <= 1'b0;
      hold        <= 1'b0;
      active      <= 1'b0;
      out_valid   <= 1'b0;
      prog_ok     <= 1'b0;
      leg_done    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r   <= func;
            now_r    <= now_wide[TIME_WIDTH-1:0];
            stop_r   <= stop_request;
            prog_ok  <= 1'b0;
            leg_done <= 1'b0;
            if ((func == FN_TICK || func == FN_PAUSE) && active && !hold) begin
              state <= S_SUB;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SUB: begin
          acc   <= AW'(alu_sum[TIME_WIDTH-1:0]);
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= AW'(alu_sum[TIME_WIDTH-1:0]);
          state <= (func_r == FN_PAUSE) ? S_OUT : S_DLY;
        end
        S_DLY: begin
          if (alu_carry) begin
            acc   <= alu_sum;
            state <= S_CMP;
          end else begin
            state <= S_OUT;
          end
        end
        S_CMP: begin
          prog_ok  <= 1'b1;
          leg_done <= alu_carry;
          if (alu_carry) begin
            q     <= ONE;
            state <= rev ? S_MIR : S_OUT;
          end else begin
            q     <= '0;
            cnt   <= CW'(FRAC_BITS - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (alu_carry) begin
            acc <= alu_sum;
            q   <= {q[PW-2:0], 1'b1};
          end else begin
            acc <= {acc[AW-2:0], 1'b0};
            q   <= {q[PW-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= rev ? S_MIR : S_OUT;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        S_MIR: begin
          q     <= alu_sum[PW-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            leg_start      <= leg_start_next;
            banked         <= banked_next;
            cycles_left    <= cycles_left_next;
            rev            <= rev_next;
            hold           <= hold_next;
            active         <= active_next;
            progress       <= o_prog;
            progress_valid <= o_pv;
            finished       <= o_fin;
            running        <= active_next;
            is_paused      <= active_next && hold_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_paused_needs_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_paused |-> running)
    else $error("paused result without an active run");

  a_finish_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !running)
    else $error("finished result while run still active");

  a_progress_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !progress_valid |-> progress == '0)
    else $error("progress nonzero without progress_valid");

  a_progress_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> progress <= ONE)
    else $error("progress above one");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> acc < AW'(dur))
    else $error("division remainder not below duration");

endmodule

// ===== sim/tb_animation_timeline_stepper.sv =====
// Testbench for animation_timeline_stepper: directed command table, then random runs.
module tb_animation_timeline_stepper;
  import ats_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0]       Q_ONE     = 17'h10000;
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  typedef struct {
    logic [16:0] prog;
    bit          pv;
    bit          fin;
    bit          run;
    bit          pau;
  } beat_t;

  typedef struct {
    bit          is_cfg;
    logic [15:0] dl;
    logic [15:0] du;
    logic [16:0] lp;
    bit          yy;
    logic [2:0]  fn;
    logic [31:0] t;
    bit          s;
    bit          typed;
    beat_t       want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func = '0;
  logic [31:0]           now_time = '0;
  logic                  stop_request = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [16:0]           progress;
  logic                  progress_valid;
  logic                  finished;
  logic                  running;
  logic                  is_paused;

  // timeline predictor: registers and run state
  logic [15:0]        dly_cfg = 16'd0;
  logic [15:0]        dur_cfg = 16'd1;
  logic signed [16:0] loops_cfg = 17'sd1;
  bit                 yoyo_cfg = 1'b0;
  logic [31:0]        tl_leg_t0 = '0;
  logic [31:0]        tl_banked = '0;
  logic [15:0]        tl_cycles = '0;
  bit                 tl_rev = 1'b0;
  bit                 tl_hold = 1'b0;
  bit                 tl_live = 1'b0;

  beat_t pending_q[$];
  int    err_count = 0;
  int    beat_no = 0;
  bit    idle_on = 1'b1;
  int    stall_burst = 0;

  animation_timeline_stepper u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .now_time      (now_time),
    .stop_request  (stop_request),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .progress      (progress),
    .progress_valid(progress_valid),
    .finished      (finished),
    .running       (running),
    .is_paused     (is_paused)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH beat %0d: %s", beat_no, msg);
    err_count++;
  endtask

  function automatic void end_run();
    tl_live = 1'b0;
    tl_hold = 1'b0;
    tl_rev  = 1'b0;
  endfunction

  // returns 1 when the loop budget is used up
  function automatic bit count_loop(input logic [31:0] t);
    if (!loops_cfg[16]) begin
      if (tl_cycles <= 16'd1) begin
        tl_cycles = '0;
        return 1'b1;
      end
      tl_cycles = tl_cycles - 16'd1;
    end
    tl_leg_t0 = t;
    tl_banked = '0;
    return 1'b0;
  endfunction

  function automatic beat_t step_timeline(input logic [2:0] f, input logic [31:0] t,
                                          input bit s);
    beat_t       r;
    logic [31:0] lt;
    logic [31:0] d;
    logic [31:0] dur;
    logic [47:0] num;
    logic [16:0] p;
    bit          done;
    r = '{prog: '0, pv: 1'b0, fin: 1'b0, run: 1'b0, pau: 1'b0};
    case (f)
      FN_START: begin
        tl_live   = 1'b1;
        tl_hold   = 1'b0;
        tl_rev    = 1'b0;
        tl_leg_t0 = t;
        tl_banked = '0;
        tl_cycles = loops_cfg[16] ? 16'd0 : loops_cfg[15:0];
      end
      FN_TICK: begin
        if (tl_live && !tl_hold) begin
          lt = t - tl_leg_t0 + tl_banked;
          if (lt >= 32'(dly_cfg)) begin
            d    = lt - 32'(dly_cfg);
            dur  = (dur_cfg == 16'd0) ? 32'd1 : 32'(dur_cfg);
            done = d >= dur;
            num  = {d[31:0], 16'b0};
            p    = done ? Q_ONE : 17'(num / 48'(dur));
            r.prog = tl_rev ? Q_ONE - p : p;
            r.pv   = 1'b1;
            if (s) begin
              r.fin = 1'b1;
              end_run();
            end else if (done) begin
              if (yoyo_cfg) begin
                tl_rev = !tl_rev;
                if (!tl_rev) begin
                  r.fin = count_loop(t);
                end else begin
                  tl_leg_t0 = t;
                  tl_banked = '0;
                end
              end else begin
                r.fin = count_loop(t);
              end
              if (r.fin) end_run();
            end
          end
        end
      end
      FN_PAUSE: begin
        if (tl_live && !tl_hold) begin
          tl_banked = tl_banked + t - tl_leg_t0;
          tl_hold   = 1'b1;
        end
      end
      FN_RESUME: begin
        if (tl_live && tl_hold) begin
          tl_leg_t0 = t;
          tl_hold   = 1'b0;
        end
      end
      FN_FINISH: begin
        if (tl_live) begin
          r.prog = tl_rev ? 17'd0 : Q_ONE;
          r.pv   = 1'b1;
          r.fin  = 1'b1;
          end_run();
        end
      end
      FN_CANCEL: begin
        if (tl_live) end_run();
      end
      default: begin
      end
    endcase
    r.run = tl_live;
    r.pau = tl_live && tl_hold;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [15:0] dl, input logic [15:0] du,
                                   input logic [16:0] lp, input bit yy);
    row_t r;
    r = '{is_cfg: 1'b1, dl: dl, du: du, lp: lp, yy: yy, fn: '0, t: '0, s: 1'b0,
          typed: 1'b0, want: '{prog: '0, pv: 1'b0, fin: 1'b0, run: 1'b0, pau: 1'b0}};
    return r;
  endfunction

  function automatic row_t op_row(input logic [2:0] f, input logic [31:0] t, input bit s);
    row_t r;
    r = '{is_cfg: 1'b0, dl: '0, du: '0, lp: '0, yy: 1'b0, fn: f, t: t, s: s,
          typed: 1'b0, want: '{prog: '0, pv: 1'b0, fin: 1'b0, run: 1'b0, pau: 1'b0}};
    return r;
  endfunction

  function automatic row_t chk_row(input logic [2:0] f, input logic [31:0] t, input bit s,
                                   input logic [16:0] p, input bit pv, input bit fin,
                                   input bit run, input bit pau);
    row_t r;
    r = op_row(f, t, s);
    r.typed = 1'b1;
    r.want  = '{prog: p, pv: pv, fin: fin, run: run, pau: pau};
    return r;
  endfunction

  task automatic send_cmd(input logic [2:0] f, input logic [31:0] t, input bit s,
                          input bit typed, input beat_t want);
    beat_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    now_time     <= t;
    stop_request <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = step_timeline(f, t, s);
    pending_q.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] dl, input logic [15:0] du,
                            input logic [16:0] lp, input bit yy);
    cfg_index_t  idx[4];
    logic [16:0] vals[4];
    idx  = '{CFG_DELAY, CFG_DURATION, CFG_LOOPS, CFG_YOYO};
    vals = '{17'(dl), 17'(du), lp, 17'(yy)};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        CFG_DELAY:    dly_cfg = vals[i][15:0];
        CFG_DURATION: dur_cfg = vals[i][15:0];
        CFG_LOOPS:    loops_cfg = vals[i];
        CFG_YOYO:     yoyo_cfg = vals[i][0];
        default: begin
        end
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      out_stall   <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall   <= 1'b1;
      stall_burst <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beats
    beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = pending_q.pop_front();
        if (progress !== e.prog)
          report_mismatch($sformatf("progress %0d, want %0d", progress, e.prog));
        if (progress_valid !== e.pv)
          report_mismatch($sformatf("progress_valid %0b, want %0b", progress_valid, e.pv));
        if (finished !== e.fin)
          report_mismatch($sformatf("finished %0b, want %0b", finished, e.fin));
        if (running !== e.run)
          report_mismatch($sformatf("running %0b, want %0b", running, e.run));
        if (is_paused !== e.pau)
          report_mismatch($sformatf("is_paused %0b, want %0b", is_paused, e.pau));
      end
      beat_no++;
    end
  end

  initial begin
    row_t        dir_tab[27];
    logic [31:0] clk_ms;
    logic [2:0]  f;
    bit          s;
    logic [15:0] dl;
    logic [15:0] du;
    logic [16:0] lp;
    bit          yy;
    int          r;
    int          step_max;

    dir_tab = '{
      chk_row(FN_TICK,   32'd0,         1'b0, 17'd0, 0, 0, 0, 0),
      chk_row(FN_PAUSE,  32'd0,         1'b1, 17'd0, 0, 0, 0, 0),
      chk_row(FN_RESUME, 32'hFFFF_FFFF, 1'b0, 17'd0, 0, 0, 0, 0),
      chk_row(FN_FINISH, 32'd0,         1'b0, 17'd0, 0, 0, 0, 0),
      chk_row(FN_CANCEL, 32'd0,         1'b0, 17'd0, 0, 0, 0, 0),
      chk_row(FN_START,  32'd100,       1'b1, 17'd0, 0, 0, 1, 0),
      chk_row(FN_TICK,   32'd100,       1'b0, 17'd0, 1, 0, 1, 0),
      chk_row(FN_TICK,   32'd101,       1'b0, Q_ONE, 1, 1, 0, 0),
      chk_row(FN_START,  32'hFFFF_FFF0, 1'b0, 17'd0, 0, 0, 1, 0),
      chk_row(FN_PAUSE,  32'hFFFF_FFF0, 1'b0, 17'd0, 0, 0, 1, 1),
      chk_row(FN_TICK,   32'hFFFF_FFFF, 1'b1, 17'd0, 0, 0, 1, 1),
      chk_row(FN_FINISH, 32'hFFFF_FFFF, 1'b0, Q_ONE, 1, 1, 0, 0),
      chk_row(FN_START,  32'd5,         1'b0, 17'd0, 0, 0, 1, 0),
      chk_row(FN_CANCEL, 32'd6,         1'b0, 17'd0, 0, 0, 0, 0),
      chk_row(FN_SPARE6, 32'hFFFF_FFFF, 1'b1, 17'd0, 0, 0, 0, 0),
      chk_row(FN_SPARE7, 32'd0,         1'b0, 17'd0, 0, 0, 0, 0),
      cfg_row(16'hFFFF, 16'd0, 17'h1FFFF, 1'b1),
      chk_row(FN_START,  32'hFFFF_0000, 1'b0, 17'd0, 0, 0, 1, 0),
      chk_row(FN_TICK,   32'hFFFF_FFFE, 1'b0, 17'd0, 0, 0, 1, 0),
      chk_row(FN_TICK,   32'hFFFF_FFFF, 1'b0, 17'd0, 1, 0, 1, 0),
      chk_row(FN_TICK,   32'd0,         1'b0, Q_ONE, 1, 0, 1, 0),
      op_row(FN_TICK,    32'd65535,     1'b0),
      op_row(FN_TICK,    32'd65536,     1'b1),
      cfg_row(16'd0, 16'hFFFF, 17'd0, 1'b0),
      op_row(FN_START,   32'd0,         1'b0),
      op_row(FN_TICK,    32'd32767,     1'b0),
      op_row(FN_TICK,    32'd65535,     1'b0)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        set_config(dir_tab[i].dl, dir_tab[i].du, dir_tab[i].lp, dir_tab[i].yy);
      else
        send_cmd(dir_tab[i].fn, dir_tab[i].t, dir_tab[i].s, dir_tab[i].typed,
                 dir_tab[i].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0:       dl = 16'd0;
        1:       dl = 16'hFFFF;
        default: dl = 16'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 6))
        0:       du = 16'd0;
        1:       du = 16'hFFFF;
        2:       du = 16'd1;
        default: du = 16'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 7))
        0:       lp = 17'h1FFFF;
        1:       lp = 17'h00000;
        2:       lp = 17'h10000;
        3:       lp = 17'h0FFFF;
        default: lp = 17'($urandom_range(1, 4));
      endcase
      yy = 1'($urandom_range(0, 1));
      set_config(dl, du, lp, yy);
      idle_on  = (ph < 8) && ($urandom_range(0, 3) != 0);
      step_max = (int'(dl) + int'(du)) / 6 + 2;
      clk_ms   = $urandom;
      for (int k = 0; k < 50; k++) begin
        r = $urandom_range(0, 99);
        if (!tl_live)
          f = (r < 75) ? FN_START : 3'($urandom_range(0, 7));
        else if (r < 68) f = FN_TICK;
        else if (r < 74) f = FN_PAUSE;
        else if (r < 80) f = FN_RESUME;
        else if (r < 84) f = FN_FINISH;
        else if (r < 88) f = FN_CANCEL;
        else if (r < 93) f = FN_START;
        else             f = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 39) == 0)
          clk_ms = $urandom;
        else
          clk_ms = clk_ms + 32'($urandom_range(0, step_max));
        s = (f == FN_TICK) ? ($urandom_range(0, 29) == 0) : 1'($urandom_range(0, 1));
        send_cmd(f, clk_ms, s, 1'b0, '{prog: '0, pv: 1'b0, fin: 1'b0, run: 1'b0, pau: 1'b0});
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
